@@ design/pit_pkg.sv @@
// Shared types and constants of the point-in-polygon test unit.
`timescale 1ns / 1ps
package pit_pkg;

  localparam int COORD_W  = 16;
  localparam int VERTEX_W = 2 * COORD_W;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREV,
    ST_LOAD,
    ST_MUL_A,
    ST_MUL_B,
    ST_DONE
  } state_e;

  // Step strobes from the sequencer to the edge datapath.
  typedef struct packed {
    logic start;
    logic ld_prev;
    logic ld_edge;
    logic mul_a;
    logic mul_b;
  } edge_ctrl_t;

endpackage

@@ design/pit_in_if.sv @@
// Input channel: command word with mode and coordinates.
`timescale 1ns / 1ps
interface pit_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic signed [pit_pkg::COORD_W-1:0]  coord_x;
  logic signed [pit_pkg::COORD_W-1:0]  coord_y;

  modport source (output valid, output mode, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input mode, input coord_x, input coord_y, output ready);
endinterface

@@ design/pit_out_if.sv @@
// Output channel: one result word per command word.
`timescale 1ns / 1ps
interface pit_out_if;
  logic                             valid;
  logic                             ready;
  logic                             inside_res;
  logic                             status;
  logic [pit_pkg::CNT_OUT_W-1:0]    vertex_count_now;

  modport source (output valid, output inside_res, output status, output vertex_count_now,
                  input ready);
  modport sink   (input valid, input inside_res, input status, input vertex_count_now,
                  output ready);
endinterface

@@ design/pit_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [WIDTH-1:0]                 wr_data_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic [WIDTH-1:0]                 rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/pit_edge_unit.sv @@
// Edge datapath: coordinate differences, shared multiplier and crossing parity.
`timescale 1ns / 1ps
module pit_edge_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pit_pkg::edge_ctrl_t                 ctrl_i,
  input  logic signed [pit_pkg::COORD_W-1:0]  pt_x_i,
  input  logic signed [pit_pkg::COORD_W-1:0]  pt_y_i,
  input  logic [pit_pkg::VERTEX_W-1:0]        vertex_i,
  output logic                                straddle_o,
  output logic                                inside_o
);

  logic signed [pit_pkg::COORD_W-1:0] px_q, py_q;
  logic signed [pit_pkg::COORD_W-1:0] xj_q, yj_q;
  logic signed [pit_pkg::COORD_W-1:0] xi, yi;
  logic signed [pit_pkg::DIFF_W-1:0]  dx_q, dy_q, bx_q, by_q;
  logic signed [pit_pkg::DIFF_W-1:0]  op_a, op_b;
  logic signed [pit_pkg::PROD_W-1:0]  prod, prod_q, lhs_q;
  logic                               neg_q;
  logic                               pend_q;
  logic                               inside_q;
  logic                               left;
  logic                               toggle;

  assign xi = vertex_i[pit_pkg::COORD_W-1:0];
  assign yi = vertex_i[pit_pkg::VERTEX_W-1:pit_pkg::COORD_W];

  assign straddle_o = (yi > py_q) != (yj_q > py_q);

  // The multiplier first forms (px - xi) * (yj - yi), then (xj - xi) * (py - yi).
  assign op_a = ctrl_i.mul_b ? bx_q : dx_q;
  assign op_b = ctrl_i.mul_b ? by_q : dy_q;
  assign prod = op_a * op_b;

  // When yj < yi both sides were scaled by a negative number, so the sense flips.
  assign left   = neg_q ? (lhs_q > prod_q) : (lhs_q < prod_q);
  assign toggle = pend_q && left;
  assign inside_o = inside_q ^ toggle;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      px_q <= pt_x_i;
      py_q <= pt_y_i;
    end
    if (ctrl_i.ld_prev || ctrl_i.ld_edge) begin
      xj_q <= xi;
      yj_q <= yi;
    end
    if (ctrl_i.ld_edge) begin
      dx_q <= $signed({px_q[pit_pkg::COORD_W-1], px_q}) - $signed({xi[pit_pkg::COORD_W-1], xi});
      dy_q <= $signed({yj_q[pit_pkg::COORD_W-1], yj_q}) - $signed({yi[pit_pkg::COORD_W-1], yi});
      bx_q <= $signed({xj_q[pit_pkg::COORD_W-1], xj_q}) - $signed({xi[pit_pkg::COORD_W-1], xi});
      by_q <= $signed({py_q[pit_pkg::COORD_W-1], py_q}) - $signed({yi[pit_pkg::COORD_W-1], yi});
    end
    if (ctrl_i.mul_a || ctrl_i.mul_b) begin
      prod_q <= prod;
    end
    if (ctrl_i.mul_b) begin
      lhs_q <= prod_q;
      neg_q <= dy_q[pit_pkg::DIFF_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      pend_q   <= ctrl_i.mul_b;
      inside_q <= ctrl_i.start ? 1'b0 : inside_o;
    end
  end

endmodule

@@ design/pit_seq.sv @@
// Sequencer: command decode, vertex count, edge walk and result register.
`timescale 1ns / 1ps
module pit_seq #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [1:0]                          in_mode_i,
  output logic                                in_ready_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                out_inside_o,
  output logic                                out_status_o,
  output logic [pit_pkg::CNT_OUT_W-1:0]       out_count_o,
  output logic                                wr_en_o,
  output logic [$clog2(MAX_VERTICES)-1:0]     wr_addr_o,
  output logic                                rd_en_o,
  output logic [$clog2(MAX_VERTICES)-1:0]     rd_addr_o,
  output pit_pkg::edge_ctrl_t                 ctrl_o,
  input  logic                                straddle_i,
  input  logic                                inside_i
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  pit_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   last_idx;
  logic            out_valid_q, out_valid_d;
  logic            out_inside_q, out_inside_d;
  logic            out_status_q, out_status_d;
  logic [pit_pkg::CNT_OUT_W-1:0] out_count_q, out_count_d;
  logic            out_free;
  logic            accept;

  assign last_idx = AW'(count_q - CW'(1));
  assign out_free = !out_valid_q || out_ready_i;
  // Only used in the idle state, where the input is ready exactly when the result
  // register is free.
  assign accept   = in_valid_i && out_free;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_inside_d = out_inside_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    in_ready_o   = 1'b0;
    wr_en_o      = 1'b0;
    wr_addr_o    = AW'(count_q);
    rd_en_o      = 1'b0;
    rd_addr_o    = idx_q + AW'(1);
    ctrl_o       = '0;

    case (state_q)
      pit_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        if (accept) begin
          out_valid_d  = 1'b1;
          out_inside_d = 1'b0;
          out_status_d = 1'b0;
          out_count_d  = pit_pkg::CNT_OUT_W'(count_q);
          case (in_mode_i)
            pit_pkg::MODE_CLEAR: begin
              count_d     = '0;
              out_count_d = '0;
            end
            pit_pkg::MODE_APPEND: begin
              if (count_q < CW'(MAX_VERTICES)) begin
                wr_en_o     = 1'b1;
                count_d     = count_q + CW'(1);
                out_count_d = pit_pkg::CNT_OUT_W'(count_q + CW'(1));
              end else begin
                out_status_d = 1'b1;
              end
            end
            pit_pkg::MODE_QUERY: begin
              // An empty polygon answers at once; otherwise fetch the last vertex
              // first so that vertex zero pairs with it.
              if (count_q != '0) begin
                out_valid_d  = 1'b0;
                ctrl_o.start = 1'b1;
                rd_en_o      = 1'b1;
                rd_addr_o    = last_idx;
                state_d      = pit_pkg::ST_PREV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pit_pkg::ST_PREV: begin
        ctrl_o.ld_prev = 1'b1;
        rd_en_o        = 1'b1;
        rd_addr_o      = '0;
        idx_d          = '0;
        state_d        = pit_pkg::ST_LOAD;
      end
      pit_pkg::ST_LOAD: begin
        ctrl_o.ld_edge = 1'b1;
        if (straddle_i) begin
          state_d = pit_pkg::ST_MUL_A;
        end else if (idx_q == last_idx) begin
          state_d = pit_pkg::ST_DONE;
        end else begin
          rd_en_o = 1'b1;
          idx_d   = idx_q + AW'(1);
          state_d = pit_pkg::ST_LOAD;
        end
      end
      pit_pkg::ST_MUL_A: begin
        ctrl_o.mul_a = 1'b1;
        state_d      = pit_pkg::ST_MUL_B;
      end
      pit_pkg::ST_MUL_B: begin
        ctrl_o.mul_b = 1'b1;
        if (idx_q == last_idx) begin
          state_d = pit_pkg::ST_DONE;
        end else begin
          rd_en_o = 1'b1;
          idx_d   = idx_q + AW'(1);
          state_d = pit_pkg::ST_LOAD;
        end
      end
      pit_pkg::ST_DONE: begin
        // The last edge's compare resolves in this cycle inside the edge unit.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_inside_d = inside_i;
          out_status_d = 1'b0;
          out_count_d  = pit_pkg::CNT_OUT_W'(count_q);
          state_d      = pit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pit_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_inside_q <= out_inside_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_inside_o = out_inside_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;

endmodule

@@ design/point_in_polygon_test_unit.sv @@
// Top level of the point-in-polygon test unit.
`timescale 1ns / 1ps
// Holds a polygon of up to MAX_VERTICES vertices in a RAM and answers one result word
// for every command word: clear the polygon, append a vertex, or test whether a point
// lies inside by the crossing-number rule, with an exact signed cross-multiplication in
// place of a division. Clear, append and a query on an empty polygon are answered
// straight from the idle state. A query walks the vertices in turn: the single RAM
// read port fetches one vertex a cycle except while one 17 x 17 bit multiplier forms
// both products of a spanning edge, one after the other. The input is not ready while
// a query runs.
module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pit_in_if.sink     in_i,
  pit_out_if.source  out_o
);

  localparam int AW = $clog2(MAX_VERTICES);

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [pit_pkg::VERTEX_W-1:0]  rd_data;
  pit_pkg::edge_ctrl_t           ctrl;
  logic                          straddle;
  logic                          inside_flag;

  pit_seq #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_mode_i    (in_i.mode),
    .in_ready_o   (in_i.ready),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_inside_o (out_o.inside_res),
    .out_status_o (out_o.status),
    .out_count_o  (out_o.vertex_count_now),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .ctrl_o       (ctrl),
    .straddle_i   (straddle),
    .inside_i     (inside_flag)
  );

  pit_ram #(
    .WIDTH(pit_pkg::VERTEX_W),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i ({in_i.coord_y, in_i.coord_x}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pit_edge_unit u_edge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .pt_x_i     (in_i.coord_x),
    .pt_y_i     (in_i.coord_y),
    .vertex_i   (rd_data),
    .straddle_o (straddle),
    .inside_o   (inside_flag)
  );

endmodule
